// ===== rtl/core/tms_pkg.sv =====
`timescale 1ns / 1ps

package tms_pkg;

  localparam int ModeW = 6;
  localparam int SecW  = 16;

  typedef logic [ModeW-1:0] mode_t;
  typedef logic [SecW-1:0]  sec_t;

  // op field codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_ENTER = 1'b1;

  // mode codes
  localparam mode_t STARTLEVEL   = mode_t'(5);
  localparam mode_t CELLDELAY    = mode_t'(7);
  localparam mode_t CELLLEVEL    = mode_t'(8);
  localparam mode_t MODE_11      = mode_t'(11);
  localparam mode_t MODE_12      = mode_t'(12);
  localparam mode_t PURGE        = mode_t'(13);
  localparam mode_t MODE_21      = mode_t'(21);
  localparam mode_t TOTALMERCURY = mode_t'(22);
  localparam mode_t MODE_26      = mode_t'(26);
  localparam mode_t ELEMMERCURY  = mode_t'(27);
  localparam mode_t MODE_31      = mode_t'(31);
  localparam mode_t CALIBRATION  = mode_t'(32);
  localparam mode_t MODE_33      = mode_t'(33);

  // durations in seconds
  localparam sec_t PURGESECONDS            = sec_t'(32768);
  localparam sec_t TOTALMERCURYSECONDS     = sec_t'(720);
  localparam sec_t ELEMENTALMERCURYSECONDS = sec_t'(100);
  localparam sec_t CALIBRATIONSECONDS      = sec_t'(64);
  localparam sec_t CELLLEVELSECONDS        = sec_t'(30);
  localparam sec_t STARTLEVELSECONDS       = sec_t'(8);

  typedef struct packed {
    logic  op;
    mode_t mode_code;
  } item_t;

  typedef struct packed {
    mode_t mode_now;
    sec_t  seconds_left;
    mode_t mode_after;
    sec_t  after_seconds;
    logic  mode_changed;
  } result_t;

  // Duration of a mode; unknown codes run no timer.
  function automatic sec_t dur_of(input mode_t m);
    sec_t d;
    unique case (m)
      STARTLEVEL:   d = STARTLEVELSECONDS;
      CELLDELAY:    d = sec_t'(12);
      CELLLEVEL:    d = CELLLEVELSECONDS;
      MODE_11:      d = sec_t'(12);
      MODE_12:      d = sec_t'(30);
      PURGE:        d = PURGESECONDS;
      MODE_21:      d = sec_t'(15);
      TOTALMERCURY: d = TOTALMERCURYSECONDS;
      MODE_26:      d = sec_t'(5);
      ELEMMERCURY:  d = ELEMENTALMERCURYSECONDS;
      MODE_31:      d = sec_t'(5);
      CALIBRATION:  d = CALIBRATIONSECONDS;
      MODE_33:      d = sec_t'(10);
      default:      d = '0;
    endcase
    return d;
  endfunction

  // Fixed successor of a mode; unknown codes go to total mercury.
  function automatic mode_t next_of(input mode_t m);
    mode_t n;
    unique case (m)
      STARTLEVEL:  n = CELLDELAY;
      CELLDELAY:   n = CELLLEVEL;
      CELLLEVEL:   n = MODE_21;
      MODE_11:     n = MODE_12;
      MODE_12:     n = MODE_21;
      PURGE:       n = MODE_21;
      MODE_26:     n = ELEMMERCURY;
      MODE_31:     n = CALIBRATION;
      CALIBRATION: n = MODE_33;
      MODE_33:     n = MODE_21;
      default:     n = TOTALMERCURY;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/tms_if.sv =====
`timescale 1ns / 1ps

interface tms_in_if import tms_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  op;
  mode_t mode_code;

  modport source (output valid, op, mode_code, input ready);
  modport sink   (input valid, op, mode_code, output ready);
endinterface

interface tms_out_if import tms_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode_now;
  sec_t  seconds_left;
  mode_t mode_after;
  sec_t  after_seconds;
  logic  mode_changed;

  modport source (output valid, mode_now, seconds_left, mode_after, after_seconds,
                  mode_changed, input ready);
  modport sink   (input valid, mode_now, seconds_left, mode_after, after_seconds,
                  mode_changed, output ready);
endinterface

// ===== rtl/core/tms_in_reg.sv =====
`timescale 1ns / 1ps

module tms_in_reg import tms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  tms_in_if.sink items,
  input  logic  adv,
  output logic  item_valid,
  output item_t item
);

  logic load;

  // Register is free when empty or when its transaction moves on this cycle.
  assign items.ready = !item_valid || adv;
  assign load        = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.op        <= items.op;
      item.mode_code <= items.mode_code;
    end
  end

endmodule

// ===== rtl/core/tms_seq_core.sv =====
`timescale 1ns / 1ps

module tms_seq_core import tms_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  item_t  item,
  output logic   adv,
  tms_out_if.source results
);

  mode_t   current_mode, current_mode_next;
  sec_t    countdown, countdown_next;
  logic    changed;
  logic    fire;
  result_t res_next;
  mode_t   succ;

  assign adv  = !results.valid || results.ready;
  assign fire = item_valid && adv;

  always_comb begin
    current_mode_next = current_mode;
    countdown_next    = countdown;
    changed           = 1'b0;
    if (item.op == OP_ENTER) begin
      current_mode_next = item.mode_code;
      countdown_next    = dur_of(item.mode_code);
      changed           = 1'b1;
    end else if (countdown != '0) begin
      if (countdown == sec_t'(1)) begin
        current_mode_next = next_of(current_mode);
        countdown_next    = dur_of(next_of(current_mode));
        changed           = 1'b1;
      end else begin
        countdown_next = countdown - sec_t'(1);
      end
    end
    succ                   = next_of(current_mode_next);
    res_next.mode_now      = current_mode_next;
    res_next.seconds_left  = countdown_next;
    res_next.mode_after    = succ;
    res_next.after_seconds = dur_of(succ);
    res_next.mode_changed  = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= STARTLEVEL;
      countdown     <= STARTLEVELSECONDS;
      results.valid <= 1'b0;
    end else begin
      if (adv) begin
        results.valid <= item_valid;
      end
      if (fire) begin
        current_mode <= current_mode_next;
        countdown    <= countdown_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.mode_now      <= res_next.mode_now;
      results.seconds_left  <= res_next.seconds_left;
      results.mode_after    <= res_next.mode_after;
      results.after_seconds <= res_next.after_seconds;
      results.mode_changed  <= res_next.mode_changed;
    end
  end

endmodule

// ===== rtl/core/timed_mode_sequencer_top.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                              | Handshake
// items    | in  | op, mode_code                                        | valid/ready
// results  | out | mode_now, seconds_left, mode_after, after_seconds,   | valid/ready
//          |     | mode_changed                                         |
//
// Each transaction passes an input register, then table lookup and countdown
// logic that updates the mode state and loads the result register.
// Result valid rises when the result register is loaded. Throughput is one
// transaction per cycle while results.ready is high, set by the single state
// update per cycle. Synchronous reset puts the sequencer in the start level
// (mode 5, 8 s). A stalled result register holds both stages; items.ready
// then falls once the input register holds a transaction.

module timed_mode_sequencer_top import tms_pkg::*; (
  input logic clk,
  input logic rst,
  tms_in_if.sink    items,
  tms_out_if.source results
);

  logic  adv;        // result stage can take a new transaction
  logic  item_valid; // input register holds a transaction
  item_t item;

  tms_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  // Mode state and countdown live here, next to the result register, so a
  // following transaction always sees the state left by the one before it.
  tms_seq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .adv        (adv),
    .results    (results)
  );

endmodule
